@@ hw/rtl/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

  // Elements in one 3x3 matrix word.
  localparam int unsigned MAT_ELEMS = 9;

  // Width of an element index.
  localparam int unsigned IDX_W = 4;

  // Operand indices for the adjugate entries, in output order. Entry j
  // is m[a0]*m[b0] - m[a1]*m[b1]; step = 2*j + term.
  function automatic logic [IDX_W-1:0] op_a(input logic [4:0] step);
    logic [IDX_W-1:0] r;
    case (step)
      5'd0:  r = 4'd4;  5'd1:  r = 4'd7;
      5'd2:  r = 4'd7;  5'd3:  r = 4'd1;
      5'd4:  r = 4'd1;  5'd5:  r = 4'd4;
      5'd6:  r = 4'd6;  5'd7:  r = 4'd3;
      5'd8:  r = 4'd0;  5'd9:  r = 4'd6;
      5'd10: r = 4'd3;  5'd11: r = 4'd0;
      5'd12: r = 4'd3;  5'd13: r = 4'd6;
      5'd14: r = 4'd6;  5'd15: r = 4'd0;
      5'd16: r = 4'd0;  5'd17: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] op_b(input logic [4:0] step);
    logic [IDX_W-1:0] r;
    case (step)
      5'd0:  r = 4'd8;  5'd1:  r = 4'd5;
      5'd2:  r = 4'd2;  5'd3:  r = 4'd8;
      5'd4:  r = 4'd5;  5'd5:  r = 4'd2;
      5'd6:  r = 4'd5;  5'd7:  r = 4'd8;
      5'd8:  r = 4'd8;  5'd9:  r = 4'd2;
      5'd10: r = 4'd2;  5'd11: r = 4'd5;
      5'd12: r = 4'd7;  5'd13: r = 4'd4;
      5'd14: r = 4'd1;  5'd15: r = 4'd7;
      5'd16: r = 4'd4;  5'd17: r = 4'd1;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mi3_front.sv @@
`default_nettype none
// Two-entry queue of accepted matrix words.
module mi3_front #(
  parameter int unsigned W = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   push,
  input  wire logic [mi3_pkg::MAT_ELEMS-1:0][W-1:0]   push_mat,
  output logic                                        full,
  output logic                                        pop_valid,
  input  wire logic                                   pop,
  output logic [mi3_pkg::MAT_ELEMS-1:0][W-1:0]        pop_mat
);

  logic [1:0][mi3_pkg::MAT_ELEMS-1:0][W-1:0] q_r;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_mat   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_mat;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mi3_back.sv @@
`default_nettype none
// Sequencer: cofactors on one shared multiplier, serial determinant,
// then, for a nonzero determinant, one restoring division per element.
module mi3_back #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   take_valid,
  input  wire logic [mi3_pkg::MAT_ELEMS-1:0][W-1:0]   take_mat,
  output logic                                        take,
  output logic                                        res_valid,
  output logic [mi3_pkg::MAT_ELEMS-1:0][W-1:0]        res_inv,
  output logic                                        res_singular,
  output logic                                        res_saturated
);

  localparam int unsigned CW   = 2 * W + 1;
  localparam int unsigned DW   = 3 * W + 3;
  localparam int unsigned NW   = CW + 2 * F;
  localparam int unsigned CNTW = $clog2(NW + 1);
  localparam int unsigned NE   = mi3_pkg::MAT_ELEMS;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_COF  = 9'b000000010,
    S_DLD  = 9'b000000100,
    S_DRUN = 9'b000001000,
    S_CHK  = 9'b000010000,
    S_QLD  = 9'b000100000,
    S_QRUN = 9'b001000000,
    S_QEND = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t                        st_r;
  logic [NE-1:0][W-1:0]          m_r;
  logic signed [CW-1:0]          acc_r;
  logic [NE-1:0][CW-1:0]         cof_r;
  logic signed [DW-1:0]          det_r, mc_r;
  logic [CW-1:0]                 mul_r;
  logic [1:0]                    t_r;
  logic [CNTW-1:0]               cnt_r;
  logic [3:0]                    idx_r;
  logic [NW-1:0]                 num_r, quo_r;
  logic [DW-1:0]                 rem_r, dmag_r;
  logic                          neg_r, sat_r;
  logic [NE-1:0][W-1:0]          res_r;

  logic [4:0]                    step;
  logic signed [W-1:0]           opa, opb;
  logic signed [2*W-1:0]         prod;
  logic signed [CW-1:0]          prod_x;
  logic [DW:0]                   trial;
  logic                          fits;
  logic [CW-1:0]                 cmag;
  logic [NW-1:0]                 lim, qs;
  logic                          over;
  logic [W-1:0]                  qv;
  logic [3:0]                    row_idx;
  logic [3:0]                    t_idx;

  assign step    = cnt_r[4:0];
  assign opa     = m_r[mi3_pkg::op_a(step)];
  assign opb     = m_r[mi3_pkg::op_b(step)];
  assign prod    = opa * opb;
  assign prod_x  = CW'(prod);
  assign trial   = {rem_r, num_r[NW-1]};
  assign fits    = (trial >= {1'b0, dmag_r});
  assign cmag    = cof_r[0][CW-1] ? (~cof_r[0] + 1'b1) : cof_r[0];
  assign lim     = (NW'(1) << (W - 1)) - (neg_r ? NW'(0) : NW'(1));
  assign over    = (quo_r > lim);
  assign qs      = over ? lim : quo_r;
  assign qv      = neg_r ? (~qs[W-1:0] + 1'b1) : qs[W-1:0];
  // First-column element of row t is element 3*t.
  assign t_idx   = {2'b00, t_r};
  assign row_idx = {1'b0, t_r, 1'b0} + t_idx;

  assign take          = (st_r == S_IDLE) && take_valid;
  assign res_valid     = (st_r == S_OUT);
  assign res_inv       = res_r;
  assign res_saturated = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (take_valid) begin
            m_r          <= take_mat;
            cnt_r        <= '0;
            sat_r        <= 1'b0;
            res_singular <= 1'b0;
            st_r         <= S_COF;
          end
        end
        S_COF: begin
          if (!cnt_r[0]) begin
            acc_r <= prod_x;
          end else begin
            cof_r <= {CW'(acc_r - prod_x), cof_r[NE-1:1]};
          end
          cnt_r <= cnt_r + 1'b1;
          if (step == 5'd17) begin
            t_r   <= 2'd0;
            det_r <= '0;
            st_r  <= S_DLD;
          end
        end
        S_DLD: begin
          mc_r  <= DW'($signed(m_r[row_idx]));
          mul_r <= cof_r[t_idx];
          cnt_r <= '0;
          st_r  <= S_DRUN;
        end
        S_DRUN: begin
          if (mul_r[0]) begin
            if (cnt_r == CNTW'(CW - 1)) det_r <= det_r - mc_r;
            else det_r <= det_r + mc_r;
          end
          mc_r  <= mc_r <<< 1;
          mul_r <= mul_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(CW - 1)) begin
            t_r <= t_r + 1'b1;
            st_r <= (t_r == 2'd2) ? S_CHK : S_DLD;
          end
        end
        S_CHK: begin
          idx_r  <= '0;
          dmag_r <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
          if (det_r == '0) begin
            res_r        <= '0;
            res_singular <= 1'b1;
            st_r         <= S_OUT;
          end else begin
            st_r <= S_QLD;
          end
        end
        S_QLD: begin
          num_r <= NW'(cmag) << (2 * F);
          neg_r <= cof_r[0][CW-1] ^ det_r[DW-1];
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= '0;
          st_r  <= S_QRUN;
        end
        S_QRUN: begin
          rem_r <= fits ? DW'(trial - {1'b0, dmag_r}) : DW'(trial);
          quo_r <= {quo_r[NW-2:0], fits};
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(NW - 1)) st_r <= S_QEND;
        end
        S_QEND: begin
          res_r <= {qv, res_r[NE-1:1]};
          if (over) sat_r <= 1'b1;
          cof_r <= {cof_r[0], cof_r[NE-1:1]};
          idx_r <= idx_r + 1'b1;
          st_r  <= (idx_r == 4'd8) ? S_OUT : S_QLD;
        end
        S_OUT: begin
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/matrix3_inverse.sv @@
`default_nettype none
// Inverse of one 3x3 signed fixed-point matrix per word (Q16.16 by default).
// Pulse start with the nine elements while busy is low; the word is queued
// (two words deep) and busy rises only when the queue is full. Each result
// word appears for exactly one cycle with out_valid high and cannot be held
// off. The back-end time per word is set by the serial determinant and the
// one-bit-a-cycle restoring divider, which runs once for each of the nine
// elements. A zero determinant gives zeros with out_singular set after the
// determinant phase; an element beyond the word range is clamped and
// out_saturated is set.
module matrix3_inverse #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [WORD_WIDTH-1:0] in_00,
  input  wire logic [WORD_WIDTH-1:0] in_01,
  input  wire logic [WORD_WIDTH-1:0] in_02,
  input  wire logic [WORD_WIDTH-1:0] in_10,
  input  wire logic [WORD_WIDTH-1:0] in_11,
  input  wire logic [WORD_WIDTH-1:0] in_12,
  input  wire logic [WORD_WIDTH-1:0] in_20,
  input  wire logic [WORD_WIDTH-1:0] in_21,
  input  wire logic [WORD_WIDTH-1:0] in_22,
  output logic                       out_valid,
  output logic [WORD_WIDTH-1:0]      out_inv_00,
  output logic [WORD_WIDTH-1:0]      out_inv_01,
  output logic [WORD_WIDTH-1:0]      out_inv_02,
  output logic [WORD_WIDTH-1:0]      out_inv_10,
  output logic [WORD_WIDTH-1:0]      out_inv_11,
  output logic [WORD_WIDTH-1:0]      out_inv_12,
  output logic [WORD_WIDTH-1:0]      out_inv_20,
  output logic [WORD_WIDTH-1:0]      out_inv_21,
  output logic [WORD_WIDTH-1:0]      out_inv_22,
  output logic                       out_singular,
  output logic                       out_saturated
);

  logic [mi3_pkg::MAT_ELEMS-1:0][WORD_WIDTH-1:0] in_mat, q_mat, inv;
  logic full, q_valid, take;

  // Element k of the packed word is the element at row k/3, column k%3.
  assign in_mat = {in_22, in_21, in_20, in_12, in_11, in_10, in_02, in_01, in_00};
  assign busy   = full;

  mi3_front #(.W(WORD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !full),
    .push_mat  (in_mat),
    .full      (full),
    .pop_valid (q_valid),
    .pop       (take),
    .pop_mat   (q_mat)
  );

  mi3_back #(.W(WORD_WIDTH), .F(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .take_valid    (q_valid),
    .take_mat      (q_mat),
    .take          (take),
    .res_valid     (out_valid),
    .res_inv       (inv),
    .res_singular  (out_singular),
    .res_saturated (out_saturated)
  );

  assign out_inv_00 = inv[0];
  assign out_inv_01 = inv[1];
  assign out_inv_02 = inv[2];
  assign out_inv_10 = inv[3];
  assign out_inv_11 = inv[4];
  assign out_inv_12 = inv[5];
  assign out_inv_20 = inv[6];
  assign out_inv_21 = inv[7];
  assign out_inv_22 = inv[8];

endmodule
`default_nettype wire
